### rtl/ssrf_pkg.sv
// ----------------------------------------------------------------------------
// ssrf_pkg
// types, segment codes and the digit table of the reading formatter
// ----------------------------------------------------------------------------
package ssrf_pkg;

  typedef enum logic [0:0] {
    OP_BIG   = 1'b0,
    OP_SMALL = 1'b1
  } opcode_t;

  typedef logic [7:0] seg_byte_t;

  localparam int unsigned IMAGE_BYTES = 7;

  localparam seg_byte_t SEG_H = 8'h6E;
  localparam seg_byte_t SEG_I = 8'h40;
  localparam seg_byte_t SEG_L = 8'hE0;
  localparam seg_byte_t SEG_O = 8'hCC;

  localparam seg_byte_t LEAD_ONE   = 8'h08;
  localparam seg_byte_t DEC_POINT  = 8'h08;
  localparam seg_byte_t MINUS_WIDE = 8'h01;
  localparam seg_byte_t MINUS_NARROW = 8'h04;
  localparam seg_byte_t SYM_DEGREE = 8'h02;
  localparam seg_byte_t SYM_DASH   = 8'h01;
  localparam seg_byte_t SYM_UNDER  = 8'h04;
  localparam seg_byte_t PERCENT    = 8'h01;

  localparam logic signed [15:0] BIG_HI_LIMIT = 16'sd19995;
  localparam logic signed [15:0] BIG_LO_LIMIT = -16'sd9995;
  localparam logic signed [15:0] BIG_POINT_LIMIT = 16'sd1999;
  localparam logic signed [15:0] SMALL_HI_LIMIT = 16'sd99;
  localparam logic signed [15:0] SMALL_LO_LIMIT = -16'sd9;

  function automatic seg_byte_t seg_of_digit(input logic [3:0] d);
    seg_byte_t s;
    case (d)
      4'd0:    s = 8'hFA;
      4'd1:    s = 8'h0A;
      4'd2:    s = 8'hD6;
      4'd3:    s = 8'h9E;
      4'd4:    s = 8'h2E;
      4'd5:    s = 8'hBC;
      4'd6:    s = 8'hFC;
      4'd7:    s = 8'h1A;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hBE;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

### rtl/seven_segment_reading_formatter_top.sv
// ----------------------------------------------------------------------------
// seven_segment_reading_formatter_top
// keeps a seven-byte lcd segment image and updates it from one reading a word
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  in      | in_valid / in_stall  | opcode, number, symbol_code, percent_sign
//  out     | out_valid / out_stall| image_byte_0 .. image_byte_6
//
//  one word per cycle while the output is not stalled; an accepted word goes
//  to the output through the input register, then the image register
//  the formatting is one pass of constant multiplies and digit selection
//  reset sets every image byte to 0xff and empties both registers
//  while a result is stalled the input register still takes one more word
// ----------------------------------------------------------------------------
module seven_segment_reading_formatter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [0:0]         opcode,
  input  logic signed [15:0] number,
  input  logic [2:0]         symbol_code,
  input  logic [0:0]         percent_sign,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         image_byte_0,
  output logic [7:0]         image_byte_1,
  output logic [7:0]         image_byte_2,
  output logic [7:0]         image_byte_3,
  output logic [7:0]         image_byte_4,
  output logic [7:0]         image_byte_5,
  output logic [7:0]         image_byte_6
);

  logic                in_full;
  ssrf_pkg::opcode_t   in_op;
  logic signed [15:0]  in_num;
  logic [2:0]          in_sym;
  logic                in_pct;
  logic                advance;

  ssrf_pkg::seg_byte_t image      [ssrf_pkg::IMAGE_BYTES];
  ssrf_pkg::seg_byte_t image_next [ssrf_pkg::IMAGE_BYTES];

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_op  <= ssrf_pkg::opcode_t'(opcode);
      in_num <= number;
      in_sym <= symbol_code;
      in_pct <= percent_sign[0];
    end
  end

  // big field arithmetic
  logic               big_hi, big_lo, big_rnd, v_neg;
  logic signed [16:0] v_ext, x_ext;
  logic [14:0]        x;
  logic [30:0]        p10;
  logic [27:0]        p100;
  logic [28:0]        p1000;
  logic [10:0]        q10;
  logic [7:0]         q100;
  logic [4:0]         q1000;
  logic [10:0]        m;
  logic [7:0]         t;
  logic [4:0]         h;
  logic [10:0]        ones_w;
  logic [7:0]         tens_w;
  logic [4:0]         hund_w;
  ssrf_pkg::seg_byte_t big_b1, big_b2, big_b3;

  assign v_ext   = {in_num[15], in_num};
  assign v_neg   = in_num[15];
  assign big_hi  = in_num > ssrf_pkg::BIG_HI_LIMIT;
  assign big_lo  = in_num < ssrf_pkg::BIG_LO_LIMIT;
  assign big_rnd = (in_num > ssrf_pkg::BIG_POINT_LIMIT) ||
                   (in_num < -ssrf_pkg::BIG_POINT_LIMIT);

  always_comb begin
    if (big_rnd) begin
      x_ext = v_neg ? (-v_ext - 17'sd5) : (v_ext + 17'sd5);
    end else begin
      x_ext = v_neg ? -v_ext : v_ext;
    end
  end

  assign x     = x_ext[14:0];
  assign p10   = 31'(x) * 31'd52429;
  assign p100  = 28'(x) * 28'd5243;
  assign p1000 = 29'(x) * 29'd8389;
  assign q10   = p10[29:19];
  assign q100  = p100[26:19];
  assign q1000 = p1000[27:23];

  assign m = big_rnd ? q10  : x[10:0];
  assign t = big_rnd ? q100 : q10[7:0];
  assign h = big_rnd ? q1000 : q100[4:0];

  assign ones_w = m - {t, 3'b000} - {2'b00, t, 1'b0};
  assign tens_w = t - {h[4:0], 3'b000} - {2'b00, h, 1'b0};
  assign hund_w = (h >= 5'd20) ? (h - 5'd20) :
                  (h >= 5'd10) ? (h - 5'd10) : h;

  always_comb begin
    big_b3 = '0;
    if (in_sym[0]) big_b3 = big_b3 | ssrf_pkg::SYM_DEGREE;
    if (in_sym[1]) big_b3 = big_b3 | ssrf_pkg::SYM_DASH;
    if (in_sym[2]) big_b3 = big_b3 | ssrf_pkg::SYM_UNDER;
    if (!big_hi && !big_lo && !big_rnd) big_b3 = big_b3 | ssrf_pkg::DEC_POINT;
    big_b1 = '0;
    if (v_neg) begin
      big_b1 = (m > 11'd99) ? ssrf_pkg::MINUS_WIDE : ssrf_pkg::MINUS_NARROW;
    end
    if (m > 11'd99) big_b1 = big_b1 | ssrf_pkg::seg_of_digit(hund_w[3:0]);
    big_b2 = ssrf_pkg::seg_of_digit(tens_w[3:0]);
  end

  // small field arithmetic
  logic               sm_hi, sm_lo;
  logic [6:0]         sm_m;
  logic [14:0]        sm_p;
  logic [3:0]         sm_t;
  logic [6:0]         sm_o;
  ssrf_pkg::seg_byte_t sm_pct;

  assign sm_hi  = in_num > ssrf_pkg::SMALL_HI_LIMIT;
  assign sm_lo  = in_num < ssrf_pkg::SMALL_LO_LIMIT;
  assign sm_m   = v_neg ? 7'(-in_num) : in_num[6:0];
  assign sm_p   = 15'(sm_m) * 15'd205;
  assign sm_t   = sm_p[14:11];
  assign sm_o   = sm_m - {sm_t, 3'b000} - {2'b00, sm_t, 1'b0};
  assign sm_pct = in_pct ? ssrf_pkg::PERCENT : '0;

  always_comb begin
    for (int i = 0; i < ssrf_pkg::IMAGE_BYTES; i++) begin
      image_next[i] = image[i];
    end
    unique case (in_op)
      ssrf_pkg::OP_BIG: begin
        image_next[3] = big_b3;
        image_next[4] = '0;
        if (big_hi) begin
          image_next[1] = ssrf_pkg::SEG_H;
          image_next[2] = ssrf_pkg::SEG_I;
        end else if (big_lo) begin
          image_next[1] = ssrf_pkg::SEG_L;
          image_next[2] = ssrf_pkg::SEG_O;
        end else begin
          image_next[0] = (m > 11'd999) ? (image[0] | ssrf_pkg::LEAD_ONE)
                                        : (image[0] & ~ssrf_pkg::LEAD_ONE);
          image_next[1] = big_b1;
          image_next[2] = big_b2;
          image_next[4] = ssrf_pkg::seg_of_digit(ones_w[3:0]);
        end
      end
      ssrf_pkg::OP_SMALL: begin
        if (sm_hi) begin
          image_next[5] = ssrf_pkg::SEG_H;
          image_next[6] = sm_pct | ssrf_pkg::SEG_I;
        end else if (sm_lo) begin
          image_next[5] = ssrf_pkg::SEG_L;
          image_next[6] = sm_pct | ssrf_pkg::SEG_O;
        end else begin
          image_next[5] = v_neg ? ssrf_pkg::MINUS_NARROW : '0;
          if (sm_m > 7'd9) image_next[5] = ssrf_pkg::seg_of_digit(sm_t);
          image_next[6] = sm_pct | ssrf_pkg::seg_of_digit(sm_o[3:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < ssrf_pkg::IMAGE_BYTES; i++) begin
        image[i] <= 8'hFF;
      end
    end else if (advance) begin
      out_valid <= 1'b1;
      for (int i = 0; i < ssrf_pkg::IMAGE_BYTES; i++) begin
        image[i] <= image_next[i];
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign image_byte_0 = image[0];
  assign image_byte_1 = image[1];
  assign image_byte_2 = image[2];
  assign image_byte_3 = image[3];
  assign image_byte_4 = image[4];
  assign image_byte_5 = image[5];
  assign image_byte_6 = image[6];

  // a held word is never dropped
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("input word lost while stalled");

  // big update leaves the small field alone
  a_big_keeps_small: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == ssrf_pkg::OP_BIG |=>
      $stable(image_byte_5) && $stable(image_byte_6))
    else $error("big update changed small field");

  // small update leaves the big field alone
  a_small_keeps_big: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == ssrf_pkg::OP_SMALL |=>
      $stable(image_byte_0) && $stable(image_byte_1) && $stable(image_byte_2) &&
      $stable(image_byte_3) && $stable(image_byte_4))
    else $error("small update changed big field");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives readings into the segment formatter and checks every image it returns
// against an in-bench model of the seven-byte display image; a directed table
// of limits and special readings is followed by random words, with random
// idling and stalls on both sides, a long output hold-off and an input pause
// ----------------------------------------------------------------------------
module testbench;

  typedef logic [6:0][7:0] image_t;

  typedef struct {
    ssrf_pkg::opcode_t  op;
    logic signed [15:0] num;
    logic [2:0]         sym;
    logic               pct;
    logic               typed;
    image_t             img;
  } reading_row_t;

  localparam int RANDOM_WORDS = 2000;
  localparam int HOLD_CYCLES  = 60;
  localparam int STALL_LIMIT  = 2000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [0:0]         opcode;
  logic signed [15:0] number;
  logic [2:0]         symbol_code;
  logic [0:0]         percent_sign;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         image_byte_0;
  logic [7:0]         image_byte_1;
  logic [7:0]         image_byte_2;
  logic [7:0]         image_byte_3;
  logic [7:0]         image_byte_4;
  logic [7:0]         image_byte_5;
  logic [7:0]         image_byte_6;

  seven_segment_reading_formatter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .number       (number),
    .symbol_code  (symbol_code),
    .percent_sign (percent_sign),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .image_byte_0 (image_byte_0),
    .image_byte_1 (image_byte_1),
    .image_byte_2 (image_byte_2),
    .image_byte_3 (image_byte_3),
    .image_byte_4 (image_byte_4),
    .image_byte_5 (image_byte_5),
    .image_byte_6 (image_byte_6)
  );

  ssrf_pkg::seg_byte_t digit_look [10] = '{8'hFA, 8'h0A, 8'hD6, 8'h9E, 8'h2E,
                                           8'hBC, 8'hFC, 8'h1A, 8'hFE, 8'hBE};

  image_t       shown;
  image_t       image_due [$];
  reading_row_t drill [$];

  int  mismatches = 0;
  int  images_checked = 0;
  int  big_words = 0;
  int  small_words = 0;
  int  hold_ask = 0;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  quiet_cycles = 0;
  bit  steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void format_reading(input ssrf_pkg::opcode_t op,
                                         input logic signed [15:0] num,
                                         input logic [2:0] sym, input logic pct);
    int                  v;
    int unsigned         m;
    ssrf_pkg::seg_byte_t b1;
    ssrf_pkg::seg_byte_t b2;
    ssrf_pkg::seg_byte_t b3;
    v = num;
    if (op == ssrf_pkg::OP_BIG) begin
      b3 = '0;
      if (sym[0]) b3 |= ssrf_pkg::SYM_DEGREE;
      if (sym[1]) b3 |= ssrf_pkg::SYM_DASH;
      if (sym[2]) b3 |= ssrf_pkg::SYM_UNDER;
      shown[4] = '0;
      if (v > ssrf_pkg::BIG_HI_LIMIT) begin
        shown[1] = ssrf_pkg::SEG_H;
        shown[2] = ssrf_pkg::SEG_I;
      end else if (v < ssrf_pkg::BIG_LO_LIMIT) begin
        shown[1] = ssrf_pkg::SEG_L;
        shown[2] = ssrf_pkg::SEG_O;
      end else begin
        b1 = '0;
        b2 = '0;
        if (v > ssrf_pkg::BIG_POINT_LIMIT || v < -ssrf_pkg::BIG_POINT_LIMIT) begin
          v = (v + 5) / 10;
        end else begin
          b3 |= ssrf_pkg::DEC_POINT;
        end
        if (v < 0) begin
          v = -v;
          b1 = (v > 99) ? ssrf_pkg::MINUS_WIDE : ssrf_pkg::MINUS_NARROW;
        end
        m = v;
        if (m > 999) shown[0] |= ssrf_pkg::LEAD_ONE;
        else shown[0] &= ~ssrf_pkg::LEAD_ONE;
        if (m > 99) b1 |= digit_look[(m / 100) % 10];
        b2 |= (m > 9) ? digit_look[(m / 10) % 10] : digit_look[0];
        shown[1] = b1;
        shown[2] = b2;
        shown[4] = digit_look[m % 10];
      end
      shown[3] = b3;
    end else begin
      shown[5] = '0;
      shown[6] = pct ? ssrf_pkg::PERCENT : 8'h00;
      if (v > ssrf_pkg::SMALL_HI_LIMIT) begin
        shown[5] |= ssrf_pkg::SEG_H;
        shown[6] |= ssrf_pkg::SEG_I;
      end else if (v < ssrf_pkg::SMALL_LO_LIMIT) begin
        shown[5] |= ssrf_pkg::SEG_L;
        shown[6] |= ssrf_pkg::SEG_O;
      end else begin
        if (v < 0) begin
          v = -v;
          shown[5] = ssrf_pkg::MINUS_NARROW;
        end
        m = v;
        if (m > 9) shown[5] = digit_look[(m / 10) % 10];
        shown[6] |= digit_look[m % 10];
      end
    end
  endfunction

  function automatic logic signed [15:0] pick_reading(input ssrf_pkg::opcode_t op);
    int big_edges [12] = '{19995, -9995, 1999, -1999, 9995, 999, -999, 99, -99, 9, -9, 0};
    int small_edges [7] = '{99, 100, -9, -10, 9, 10, 0};
    int sel;
    sel = $urandom_range(9);
    if (op == ssrf_pkg::OP_BIG) begin
      case (sel)
        0, 1, 2: return 16'($urandom_range(4200) - 2100);
        3:       return 16'(big_edges[$urandom_range(11)] + $urandom_range(6) - 3);
        4, 5:    return 16'($urandom);
        default: return 16'($urandom_range(30000) - 10000);
      endcase
    end else begin
      case (sel)
        7:       return 16'(small_edges[$urandom_range(6)]);
        8, 9:    return 16'($urandom);
        default: return 16'($urandom_range(114) - 12);
      endcase
    end
  endfunction

  task automatic drill_row(input ssrf_pkg::opcode_t op, input logic signed [15:0] num,
                           input logic [2:0] sym, input logic pct,
                           input logic typed, input image_t img);
    reading_row_t r;
    r.op = op;
    r.num = num;
    r.sym = sym;
    r.pct = pct;
    r.typed = typed;
    r.img = img;
    drill.push_back(r);
  endtask

  task automatic send_word(input reading_row_t r);
    if (!steady) begin
      while ($urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    opcode       <= r.op;
    number       <= r.num;
    symbol_code  <= r.sym;
    percent_sign <= r.pct;
    do @(posedge clk); while (in_stall);
    format_reading(r.op, r.num, r.sym, r.pct);
    image_due.push_back(r.typed ? r.img : shown);
    if (r.op == ssrf_pkg::OP_BIG) big_words++;
    else small_words++;
    @(negedge clk);
  endtask

  task automatic drain_images();
    in_valid <= 1'b0;
    @(negedge clk);
    while (image_due.size() != 0) @(negedge clk);
  endtask

  // receiver: random or no stalls, or a long hold-off when the sender asks
  always @(negedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 18);
    end
  end

  always @(posedge clk) begin
    image_t got;
    image_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {image_byte_6, image_byte_5, image_byte_4, image_byte_3,
             image_byte_2, image_byte_1, image_byte_0};
      if (image_due.size() == 0) begin
        $display("%0t: image with none expected, got %h", $time, got);
        mismatches++;
      end else begin
        want = image_due.pop_front();
        images_checked++;
        for (int i = 0; i < ssrf_pkg::IMAGE_BYTES; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: image byte %0d expected %h got %h", $time, i, want[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    reading_row_t r;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = ssrf_pkg::OP_BIG;
    number       = '0;
    symbol_code  = '0;
    percent_sign = '0;

    // image literals are bytes 6 down to 0
    drill_row(ssrf_pkg::OP_BIG,    16'sd20000, 3'd7, 1'b0, 1'b1, 56'hFF_FF_00_07_40_6E_FF);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd10000, 3'd0, 1'b1, 1'b1, 56'hFF_FF_00_00_CC_E0_FF);
    drill_row(ssrf_pkg::OP_SMALL,  16'sd100,   3'd5, 1'b1, 1'b1, 56'h41_6E_00_00_CC_E0_FF);
    drill_row(ssrf_pkg::OP_SMALL, -16'sd10,    3'd7, 1'b0, 1'b1, 56'hCC_E0_00_00_CC_E0_FF);
    drill_row(ssrf_pkg::OP_BIG,    16'sd32767, 3'd1, 1'b0, 1'b1, 56'hCC_E0_00_02_40_6E_FF);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd32768, 3'd2, 1'b1, 1'b1, 56'hCC_E0_00_01_CC_E0_FF);
    drill_row(ssrf_pkg::OP_SMALL,  16'sd32767, 3'd0, 1'b0, 1'b1, 56'h40_6E_00_01_CC_E0_FF);
    drill_row(ssrf_pkg::OP_SMALL, -16'sd32768, 3'd0, 1'b1, 1'b1, 56'hCD_E0_00_01_CC_E0_FF);
    drill_row(ssrf_pkg::OP_BIG,    16'sd19995, 3'd4, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,    16'sd19996, 3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd9995,  3'd3, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd9996,  3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,    16'sd1999,  3'd6, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,    16'sd2000,  3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd1999,  3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd2000,  3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,    16'sd0,     3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd5,     3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_BIG,   -16'sd100,   3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_SMALL,  16'sd99,    3'd0, 1'b1, 1'b0, '0);
    drill_row(ssrf_pkg::OP_SMALL, -16'sd9,     3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_SMALL,  16'sd0,     3'd0, 1'b1, 1'b0, '0);
    drill_row(ssrf_pkg::OP_SMALL,  16'sd10,    3'd0, 1'b0, 1'b0, '0);
    drill_row(ssrf_pkg::OP_SMALL, -16'sd1,     3'd0, 1'b1, 1'b0, '0);

    for (int i = 0; i < ssrf_pkg::IMAGE_BYTES; i++) shown[i] = 8'hFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (drill[k]) send_word(drill[k]);
    drain_images();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      steady = (i >= 1000 && i < 1300);
      if (i == 300) hold_ask++;
      if (i == 700) drain_images();
      r.op    = ssrf_pkg::opcode_t'($urandom_range(1));
      r.num   = pick_reading(r.op);
      r.sym   = 3'($urandom_range(7));
      r.pct   = 1'($urandom_range(1));
      r.typed = 1'b0;
      r.img   = '0;
      send_word(r);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (image_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("%0d readings sent (%0d big, %0d small), %0d images checked",
             big_words + small_words, big_words, small_words, images_checked);
    $display("hi/lo limits, rounding and point bands, output hold-off and input pause covered");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### seven_segment_reading_formatter_top.f
rtl/ssrf_pkg.sv
rtl/seven_segment_reading_formatter_top.sv
test/testbench.sv
